// File: rtl/core/qhi_pkg.sv
package qhi_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int RATE_FRAC_BITS_DEF = 11;
    localparam int FIELD_WIDTH_DEF    = 16;
    localparam int STEP_BITS          = 16;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd66;

    // One request: quaternion and body rates.
    typedef struct packed {
        logic signed [FIELD_WIDTH_DEF-1:0] quat_w;
        logic signed [FIELD_WIDTH_DEF-1:0] quat_x;
        logic signed [FIELD_WIDTH_DEF-1:0] quat_y;
        logic signed [FIELD_WIDTH_DEF-1:0] quat_z;
        logic signed [FIELD_WIDTH_DEF-1:0] rate_x;
        logic signed [FIELD_WIDTH_DEF-1:0] rate_y;
        logic signed [FIELD_WIDTH_DEF-1:0] rate_z;
    } req_t;

    // One result: updated quaternion and the zero-norm flag.
    typedef struct packed {
        logic signed [FIELD_WIDTH_DEF-1:0] new_w;
        logic signed [FIELD_WIDTH_DEF-1:0] new_x;
        logic signed [FIELD_WIDTH_DEF-1:0] new_y;
        logic signed [FIELD_WIDTH_DEF-1:0] new_z;
        logic                              zero_norm;
    } rsp_t;

endpackage

// File: rtl/core/qhi_isqrt.sv
// Pipelined integer square root: one result bit per stage.
module qhi_isqrt #(
    parameter int IN_W = 34,
    parameter int OUT_W = 17,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [IN_W-1:0]   in_val,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_vld,
    output logic [OUT_W-1:0]  out_root,
    output logic [TAG_W-1:0]  out_tag
);
    localparam int RW = 2 * OUT_W;

    logic [OUT_W:0]   vld_reg;
    logic [RW-1:0]    rem_reg  [OUT_W+1];
    logic [RW-1:0]    src_reg  [OUT_W+1];
    logic [OUT_W-1:0] root_reg [OUT_W+1];
    logic [TAG_W-1:0] tag_reg  [OUT_W+1];

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[OUT_W-1:0], in_vld};
        end
    end

    // Stage 0 captures the operand.
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        src_reg[0]  <= RW'(in_val);
        root_reg[0] <= '0;
        tag_reg[0]  <= in_tag;
    end

    // Each stage brings down two operand bits and decides one root bit.
    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        always_comb
        begin
            rem_sh = {rem_reg[s], src_reg[s][RW-1 -: 2]};
            trial  = {(RW + 2 - OUT_W - 2)'(0), root_reg[s], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            src_reg[s+1] <= {src_reg[s][RW-3:0], 2'b00};
            tag_reg[s+1] <= tag_reg[s];
            if (rem_sh >= trial)
            begin
                rem_reg[s+1]  <= RW'(rem_sh - trial);
                root_reg[s+1] <= {root_reg[s][OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1]  <= RW'(rem_sh);
                root_reg[s+1] <= {root_reg[s][OUT_W-2:0], 1'b0};
            end
        end
    end

    assign out_vld  = vld_reg[OUT_W];
    assign out_root = root_reg[OUT_W];
    assign out_tag  = tag_reg[OUT_W];
endmodule

// File: rtl/core/qhi_div.sv
// Pipelined restoring divider for one lane: |q| << F / r, one quotient bit per stage.
module qhi_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 18,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_vld,
    output logic [NUM_W-1:0]  quo,
    output logic [TAG_W-1:0]  out_tag
);
    logic [NUM_W:0]   vld_reg;
    logic [DEN_W:0]   rem_reg [NUM_W+1];
    logic [NUM_W-1:0] q_reg   [NUM_W+1];
    logic [DEN_W-1:0] d_reg   [NUM_W+1];
    logic [TAG_W-1:0] tag_reg [NUM_W+1];

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NUM_W-1:0], in_vld};
        end
    end

    // Operand capture; the numerator shifts out of q as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        q_reg[0]   <= num;
        d_reg[0]   <= den;
        tag_reg[0] <= in_tag;
    end

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DEN_W+1:0] sh;
        logic [DEN_W+1:0] dif;
        always_comb
        begin
            sh  = {rem_reg[s], q_reg[s][NUM_W-1]};
            dif = sh - {2'b00, d_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            d_reg[s+1]   <= d_reg[s];
            tag_reg[s+1] <= tag_reg[s];
            if (!dif[DEN_W+1])
            begin
                rem_reg[s+1] <= dif[DEN_W:0];
                q_reg[s+1]   <= {q_reg[s][NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= sh[DEN_W:0];
                q_reg[s+1]   <= {q_reg[s][NUM_W-2:0], 1'b0};
            end
        end
    end

    assign out_vld = vld_reg[NUM_W];
    assign quo     = q_reg[NUM_W];
    assign out_tag = tag_reg[NUM_W];
endmodule

// File: rtl/core/qhi_omega.sv
// One Omega row lane: three rate*component products, each scaled by h and rounded,
// then merged into a signed row sum. Four stages.
module qhi_omega #(
    parameter int VW = 18,
    parameter int FIELD_WIDTH = 16,
    parameter int SHIFT = 28
) (
    input  logic                          clk,
    input  logic signed [FIELD_WIDTH-1:0] rate_a,
    input  logic signed [FIELD_WIDTH-1:0] rate_b,
    input  logic signed [FIELD_WIDTH-1:0] rate_c,
    input  logic signed [VW-1:0]          val_a,
    input  logic signed [VW-1:0]          val_b,
    input  logic signed [VW-1:0]          val_c,
    input  logic [2:0]                    neg,
    input  logic [qhi_pkg::STEP_BITS-1:0] step,
    output logic signed [VW+2:0]          row
);
    localparam int PW = FIELD_WIDTH + VW;
    localparam int MW = PW + qhi_pkg::STEP_BITS;
    localparam int TW = (MW - SHIFT > 1) ? MW - SHIFT + 1 : 2;

    logic signed [FIELD_WIDTH-1:0] ra [3];
    logic signed [VW-1:0]          va [3];
    logic [PW-1:0]                 pmag_reg [3];
    logic [2:0]                    psgn_reg;
    logic [MW-1:0]                 smag_reg [3];
    logic [2:0]                    ssgn_reg;
    logic signed [TW:0]            term_reg [3];
    logic [qhi_pkg::STEP_BITS-1:0] step_reg;

    assign ra[0] = rate_a;
    assign ra[1] = rate_b;
    assign ra[2] = rate_c;
    assign va[0] = val_a;
    assign va[1] = val_b;
    assign va[2] = val_c;

    for (genvar t = 0; t < 3; t++)
    begin : g_term
        logic signed [PW-1:0] prod;
        logic [MW:0]          rnd;
        always_comb
        begin
            prod = PW'(ra[t]) * PW'(va[t]);
            rnd  = {1'b0, smag_reg[t]} + ((MW + 1)'(1) << (SHIFT - 1));
        end
        // Product magnitude, then times h, then rounded shift with sign.
        always_ff @(posedge clk)
        begin
            pmag_reg[t] <= prod[PW-1] ? PW'(-prod) : PW'(prod);
            psgn_reg[t] <= prod[PW-1] ^ neg[t];
            smag_reg[t] <= MW'(pmag_reg[t] * MW'(step_reg));
            ssgn_reg[t] <= psgn_reg[t];
            term_reg[t] <= ssgn_reg[t] ? -$signed({1'b0, TW'(rnd >> SHIFT)})
                                       : $signed({1'b0, TW'(rnd >> SHIFT)});
        end
    end

    // Merge the three terms of the row.
    always_ff @(posedge clk)
    begin
        step_reg <= step;
        row <= (VW + 3)'(term_reg[0]) + (VW + 3)'(term_reg[1]) + (VW + 3)'(term_reg[2]);
    end
endmodule

// File: rtl/core/quaternion_heun_integrator_top.sv
// Pipeline: done follows the accepting edge through the sum-of-squares register, the root
//   stages, the divide stages, normalize, two four-stage Omega passes, predictor clamp and result.
// Throughput: one request per clock; busy stays low. Every stage is a fixed pipeline.
// The receiver cannot stall: each result is on the result ports for one cycle with done.
// Reset: rst_n is asynchronous, active low; it clears the valid pipeline and sets
//   step_size to 66.
module quaternion_heun_integrator_top #(
    parameter int QUAT_FRAC_BITS = qhi_pkg::QUAT_FRAC_BITS_DEF,
    parameter int RATE_FRAC_BITS = qhi_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  qhi_pkg::req_t                 req,
    output logic                          done,
    output qhi_pkg::rsp_t                 rsp,
    input  logic                          cfg_we,
    input  logic [qhi_pkg::STEP_BITS-1:0] cfg_wdata
);
    localparam int FW    = qhi_pkg::FIELD_WIDTH_DEF;
    localparam int SQW   = 2 * FW + 2;
    localparam int RTW   = FW + 1;
    localparam int NUMW  = FW + QUAT_FRAC_BITS;
    localparam int VW    = QUAT_FRAC_BITS + 3;
    localparam int SH1   = RATE_FRAC_BITS + qhi_pkg::STEP_BITS + 1;
    localparam int SH2   = SH1 + 1;
    localparam int TAGW  = 7 * FW + 1;
    localparam int DTAGW = 3 * FW + 1;
    localparam logic signed [FW-1:0] FMAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic signed [FW-1:0] FMIN = {1'b1, {(FW-1){1'b0}}};

    logic [qhi_pkg::STEP_BITS-1:0] step_reg;
    logic                          acc;
    logic signed [FW-1:0]          q_in [4];
    logic [SQW-1:0]                sq_reg;
    logic                          sq_vld_reg;
    logic [4*FW-1:0]               q_hold_reg;
    logic [3*FW-1:0]               w_hold_reg;

    assign busy = 1'b0;
    assign acc  = start && !busy;
    assign q_in[0] = req.quat_w;
    assign q_in[1] = req.quat_x;
    assign q_in[2] = req.quat_y;
    assign q_in[3] = req.quat_z;

    // Step size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= qhi_pkg::STEP_RESET;
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            sq_vld_reg <= acc;
        end
    end

    // Sum of squares; the extra width keeps it exact.
    always_ff @(posedge clk)
    begin
        sq_reg <= SQW'($unsigned((2*FW)'(q_in[0]) * (2*FW)'(q_in[0])))
                + SQW'($unsigned((2*FW)'(q_in[1]) * (2*FW)'(q_in[1])))
                + SQW'($unsigned((2*FW)'(q_in[2]) * (2*FW)'(q_in[2])))
                + SQW'($unsigned((2*FW)'(q_in[3]) * (2*FW)'(q_in[3])));
        q_hold_reg <= {req.quat_w, req.quat_x, req.quat_y, req.quat_z};
        w_hold_reg <= {req.rate_x, req.rate_y, req.rate_z};
    end

    // Square root of the norm.
    logic             rt_vld;
    logic [RTW-1:0]   rt_root;
    logic [TAGW-1:0]  rt_tag;
    logic             zero_sum;

    assign zero_sum = (sq_reg == '0);

    qhi_isqrt #(.IN_W(SQW), .OUT_W(RTW), .TAG_W(TAGW)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sq_vld_reg),
        .in_val   (sq_reg),
        .in_tag   ({zero_sum, q_hold_reg, w_hold_reg}),
        .out_vld  (rt_vld),
        .out_root (rt_root),
        .out_tag  (rt_tag)
    );

    // Four divider lanes, one per quaternion component.
    logic              dv_vld [4];
    logic [NUMW-1:0]   dv_quo [4];
    logic [DTAGW-1:0]  dv_tag [4];
    logic              dv_neg [4];
    logic [RTW-1:0]    den;

    assign den = (rt_root == '0) ? RTW'(1) : rt_root;

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        logic signed [FW-1:0] qc;
        logic [FW-1:0]        qm;
        assign qc = rt_tag[7*FW-1 - i*FW -: FW];
        assign qm = qc[FW-1] ? FW'(-qc) : FW'(qc);
        qhi_div #(.NUM_W(NUMW), .DEN_W(RTW), .TAG_W(DTAGW + 1)) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (rt_vld),
            .num     ({qm, {QUAT_FRAC_BITS{1'b0}}}),
            .den     (den),
            .in_tag  ({qc[FW-1], rt_tag[TAGW-1], rt_tag[3*FW-1:0]}),
            .out_vld (dv_vld[i]),
            .quo     (dv_quo[i]),
            .out_tag ({dv_neg[i], dv_tag[i]})
        );
    end

    // Normalized components, registered.
    logic signed [VW-1:0] n_reg [4];
    logic                 n_vld_reg;
    logic                 n_zero_reg;
    logic signed [FW-1:0] wr_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_vld_reg <= 1'b0;
        end
        else
        begin
            n_vld_reg <= dv_vld[0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            n_reg[i] <= dv_neg[i] ? -$signed(VW'(dv_quo[i])) : $signed(VW'(dv_quo[i]));
        end
        n_zero_reg <= dv_tag[0][DTAGW-1];
        wr_reg[0]  <= dv_tag[0][3*FW-1 -: FW];
        wr_reg[1]  <= dv_tag[0][2*FW-1 -: FW];
        wr_reg[2]  <= dv_tag[0][FW-1:0];
    end

    // Predictor and first corrector rows: lanes in parallel, four stages.
    logic [2:0] neg_row [4];
    assign neg_row[0] = 3'b111;
    assign neg_row[1] = 3'b001;
    assign neg_row[2] = 3'b010;
    assign neg_row[3] = 3'b100;

    logic signed [VW+2:0] f_row  [4];
    logic signed [VW+2:0] g1_row [4];
    logic signed [VW+2:0] g2_row [4];
    logic signed [VW-1:0] nv [4][3];
    logic signed [FW-1:0] rv [4][3];

    // Row 0: -wx*x - wy*y - wz*z; row 1: wx*w + wz*y - wy*z;
    // row 2: wy*w - wz*x + wx*z; row 3: wz*w + wy*x - wx*y.
    always_comb
    begin
        rv[0][0] = wr_reg[0]; nv[0][0] = n_reg[1];
        rv[0][1] = wr_reg[1]; nv[0][1] = n_reg[2];
        rv[0][2] = wr_reg[2]; nv[0][2] = n_reg[3];
        rv[1][0] = wr_reg[1]; nv[1][0] = n_reg[3];
        rv[1][1] = wr_reg[0]; nv[1][1] = n_reg[0];
        rv[1][2] = wr_reg[2]; nv[1][2] = n_reg[2];
        rv[2][0] = wr_reg[1]; nv[2][0] = n_reg[0];
        rv[2][1] = wr_reg[2]; nv[2][1] = n_reg[1];
        rv[2][2] = wr_reg[0]; nv[2][2] = n_reg[3];
        rv[3][0] = wr_reg[2]; nv[3][0] = n_reg[0];
        rv[3][1] = wr_reg[1]; nv[3][1] = n_reg[1];
        rv[3][2] = wr_reg[0]; nv[3][2] = n_reg[2];
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_pred
        qhi_omega #(.VW(VW), .FIELD_WIDTH(FW), .SHIFT(SH1)) u_f (
            .clk(clk), .rate_a(rv[i][0]), .rate_b(rv[i][1]), .rate_c(rv[i][2]),
            .val_a(nv[i][0]), .val_b(nv[i][1]), .val_c(nv[i][2]),
            .neg(neg_row[i]), .step(step_reg), .row(f_row[i])
        );
        qhi_omega #(.VW(VW), .FIELD_WIDTH(FW), .SHIFT(SH2)) u_g1 (
            .clk(clk), .rate_a(rv[i][0]), .rate_b(rv[i][1]), .rate_c(rv[i][2]),
            .val_a(nv[i][0]), .val_b(nv[i][1]), .val_c(nv[i][2]),
            .neg(neg_row[i]), .step(step_reg), .row(g1_row[i])
        );
    end

    // Delay n, rates and flags by the four omega stages.
    localparam int OD = 4;
    logic signed [VW-1:0] n_d   [OD][4];
    logic signed [FW-1:0] w_d   [OD][3];
    logic                 z_d   [OD];
    logic [OD-1:0]        v_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg <= '0;
        end
        else
        begin
            v_d_reg <= {v_d_reg[OD-2:0], n_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        n_d[0] <= n_reg;
        w_d[0] <= wr_reg;
        z_d[0] <= n_zero_reg;
        for (int k = 1; k < OD; k++)
        begin
            n_d[k] <= n_d[k-1];
            w_d[k] <= w_d[k-1];
            z_d[k] <= z_d[k-1];
        end
    end

    // Saturated predictor m.
    logic signed [FW-1:0] m_reg [4];
    logic signed [VW+2:0] g1_hold_reg [4];
    logic signed [VW-1:0] n_m_reg [4];
    logic signed [FW-1:0] w_m_reg [3];
    logic                 z_m_reg;
    logic                 m_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= v_d_reg[OD-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [VW+3:0] s;
            s = (VW + 4)'(n_d[OD-1][i]) + (VW + 4)'(f_row[i]);
            if (s > (VW + 4)'(FMAX))
            begin
                m_reg[i] <= FMAX;
            end
            else if (s < (VW + 4)'(FMIN))
            begin
                m_reg[i] <= FMIN;
            end
            else
            begin
                m_reg[i] <= FW'(s);
            end
            g1_hold_reg[i] <= g1_row[i];
            n_m_reg[i]     <= n_d[OD-1][i];
        end
        w_m_reg <= w_d[OD-1];
        z_m_reg <= z_d[OD-1];
    end

    // Second corrector on m.
    localparam int MVW = (FW > VW) ? FW : VW;
    logic signed [MVW-1:0] mv [4][3];
    logic signed [FW-1:0]  mr [4][3];
    logic signed [MVW+2:0] g2w [4];

    always_comb
    begin
        mr[0][0] = w_m_reg[0]; mv[0][0] = MVW'(m_reg[1]);
        mr[0][1] = w_m_reg[1]; mv[0][1] = MVW'(m_reg[2]);
        mr[0][2] = w_m_reg[2]; mv[0][2] = MVW'(m_reg[3]);
        mr[1][0] = w_m_reg[1]; mv[1][0] = MVW'(m_reg[3]);
        mr[1][1] = w_m_reg[0]; mv[1][1] = MVW'(m_reg[0]);
        mr[1][2] = w_m_reg[2]; mv[1][2] = MVW'(m_reg[2]);
        mr[2][0] = w_m_reg[1]; mv[2][0] = MVW'(m_reg[0]);
        mr[2][1] = w_m_reg[2]; mv[2][1] = MVW'(m_reg[1]);
        mr[2][2] = w_m_reg[0]; mv[2][2] = MVW'(m_reg[3]);
        mr[3][0] = w_m_reg[2]; mv[3][0] = MVW'(m_reg[0]);
        mr[3][1] = w_m_reg[1]; mv[3][1] = MVW'(m_reg[1]);
        mr[3][2] = w_m_reg[0]; mv[3][2] = MVW'(m_reg[2]);
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_corr
        qhi_omega #(.VW(MVW), .FIELD_WIDTH(FW), .SHIFT(SH2)) u_g2 (
            .clk(clk), .rate_a(mr[i][0]), .rate_b(mr[i][1]), .rate_c(mr[i][2]),
            .val_a(mv[i][0]), .val_b(mv[i][1]), .val_c(mv[i][2]),
            .neg(neg_row[i]), .step(step_reg), .row(g2w[i])
        );
        assign g2_row[i] = (VW + 3)'(g2w[i]);
    end

    // Hold n, g1 and flag across the second corrector.
    logic signed [VW+2:0] g1_e [OD][4];
    logic signed [VW-1:0] n_e  [OD][4];
    logic                 z_e  [OD];
    logic [OD-1:0]        v_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_e_reg <= '0;
        end
        else
        begin
            v_e_reg <= {v_e_reg[OD-2:0], m_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        g1_e[0] <= g1_hold_reg;
        n_e[0]  <= n_m_reg;
        z_e[0]  <= z_m_reg;
        for (int k = 1; k < OD; k++)
        begin
            g1_e[k] <= g1_e[k-1];
            n_e[k]  <= n_e[k-1];
            z_e[k]  <= z_e[k-1];
        end
    end

    // Final merge, saturation and result register.
    logic          done_reg;
    qhi_pkg::rsp_t rsp_reg;
    logic signed [FW-1:0] res [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [VW+4:0] s;
            s = (VW + 5)'(n_e[OD-1][i]) + (VW + 5)'(g1_e[OD-1][i]) + (VW + 5)'(g2_row[i]);
            if (z_e[OD-1])
            begin
                res[i] = '0;
            end
            else if (s > (VW + 5)'(FMAX))
            begin
                res[i] = FMAX;
            end
            else if (s < (VW + 5)'(FMIN))
            begin
                res[i] = FMIN;
            end
            else
            begin
                res[i] = FW'(s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_e_reg[OD-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg.new_w     <= res[0];
        rsp_reg.new_x     <= res[1];
        rsp_reg.new_y     <= res[2];
        rsp_reg.new_z     <= res[3];
        rsp_reg.zero_norm <= z_e[OD-1];
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v_e_reg[OD-1])) else $error("done without a request in flight");
    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.zero_norm |-> rsp.new_w == '0 && rsp.new_x == '0 && rsp.new_y == '0
        && rsp.new_z == '0) else $error("zero-norm result not cleared");
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld[0] == dv_vld[3]) else $error("divider lanes out of step");
`endif
endmodule

// File: tb/testbench.sv
module testbench;

    localparam int LATENCY_CYCLES = 80;

    // One row of the directed stimulus: the request and, where it is obvious,
    // the result that it must give.
    typedef struct {
        qhi_pkg::req_t rq;
        bit            typed;
        qhi_pkg::rsp_t want;
    } row_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    qhi_pkg::req_t   req;
    logic            done;
    qhi_pkg::rsp_t   rsp;
    logic            cfg_we;
    logic [qhi_pkg::STEP_BITS-1:0] cfg_wdata;

    // Step size as the block holds it, tracked on our side.
    logic [qhi_pkg::STEP_BITS-1:0] step_now;

    qhi_pkg::rsp_t attitude_q[$];
    int    accepted_cnt;
    int    result_cnt;
    int    zero_cnt;
    int    mismatch_cnt;
    row_t  dir_rows[$];

    // Typed expectation of the request now on the port, if any.
    row_t dir_pending;

    quaternion_heun_integrator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Floor of the square root of a sum of squares (at most 2^32).
    function automatic longint root_floor(longint sum);
        longint r;
        longint cand;
        r = 0;
        for (int i = 17; i >= 0; i--)
        begin
            cand = r | (64'sd1 <<< i);
            if (cand * cand <= sum)
                r = cand;
        end
        return r;
    endfunction

    // Product scaled by the step and shifted right, rounded half away from zero.
    function automatic longint scaled_term(longint p, int sh,
                                           logic [qhi_pkg::STEP_BITS-1:0] h);
        longint m;
        longint q;
        m = (p < 0) ? -p : p;
        q = (m * longint'(h) + (64'sd1 <<< (sh - 1))) >>> sh;
        return (p < 0) ? -q : q;
    endfunction

    // One row of the scaled Omega(w) * v product.
    function automatic longint omega_row(int row, longint wx, longint wy, longint wz,
                                         longint v0, longint v1, longint v2, longint v3,
                                         int sh, logic [qhi_pkg::STEP_BITS-1:0] h);
        case (row)
            0: return -scaled_term(wx * v1, sh, h) - scaled_term(wy * v2, sh, h)
                      - scaled_term(wz * v3, sh, h);
            1: return scaled_term(wx * v0, sh, h) + scaled_term(wz * v2, sh, h)
                      - scaled_term(wy * v3, sh, h);
            2: return scaled_term(wy * v0, sh, h) - scaled_term(wz * v1, sh, h)
                      + scaled_term(wx * v3, sh, h);
            default: return scaled_term(wz * v0, sh, h) + scaled_term(wy * v1, sh, h)
                      - scaled_term(wx * v2, sh, h);
        endcase
    endfunction

    function automatic longint clamp_field(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Normalize, then one Heun step of q_dot = 0.5 * Omega(w) * q.
    function automatic qhi_pkg::rsp_t predict_attitude(qhi_pkg::req_t r,
                                                       logic [qhi_pkg::STEP_BITS-1:0] h);
        longint q[4];
        longint nq[4];
        longint mq[4];
        longint sum;
        longint root;
        longint mg;
        longint wx;
        longint wy;
        longint wz;
        longint res[4];
        int     sh1;
        qhi_pkg::rsp_t o;
        sh1 = qhi_pkg::RATE_FRAC_BITS_DEF + qhi_pkg::STEP_BITS + 1;
        q[0] = r.quat_w;
        q[1] = r.quat_x;
        q[2] = r.quat_y;
        q[3] = r.quat_z;
        wx = r.rate_x;
        wy = r.rate_y;
        wz = r.rate_z;
        sum = 0;
        for (int i = 0; i < 4; i++)
            sum += q[i] * q[i];
        o = '0;
        if (sum == 0)
        begin
            o.zero_norm = 1'b1;
            return o;
        end
        root = root_floor(sum);
        for (int i = 0; i < 4; i++)
        begin
            mg = (q[i] < 0) ? -q[i] : q[i];
            mg = (mg <<< qhi_pkg::QUAT_FRAC_BITS_DEF) / root;
            nq[i] = (q[i] < 0) ? -mg : mg;
        end
        for (int i = 0; i < 4; i++)
            mq[i] = clamp_field(nq[i] + omega_row(i, wx, wy, wz, nq[0], nq[1], nq[2], nq[3],
                                                  sh1, h));
        for (int i = 0; i < 4; i++)
            res[i] = clamp_field(nq[i]
                + omega_row(i, wx, wy, wz, nq[0], nq[1], nq[2], nq[3], sh1 + 1, h)
                + omega_row(i, wx, wy, wz, mq[0], mq[1], mq[2], mq[3], sh1 + 1, h));
        o.new_w = res[0][15:0];
        o.new_x = res[1][15:0];
        o.new_y = res[2][15:0];
        o.new_z = res[3][15:0];
        return o;
    endfunction

    // Record each request that the block takes.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            accepted_cnt <= accepted_cnt + 1;
            if (!dir_pending.typed)
                attitude_q.push_back(predict_attitude(req, step_now));
            else
                attitude_q.push_back(dir_pending.want);
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        qhi_pkg::rsp_t exp_rsp;
        if (rst_n && done)
        begin
            result_cnt <= result_cnt + 1;
            if (attitude_q.size() == 0)
            begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= 10)
                    $display("unexpected result %h", rsp);
            end
            else
            begin
                exp_rsp = attitude_q.pop_front();
                if (exp_rsp.zero_norm)
                    zero_cnt <= zero_cnt + 1;
                if (rsp.new_w !== exp_rsp.new_w || rsp.new_x !== exp_rsp.new_x ||
                    rsp.new_y !== exp_rsp.new_y || rsp.new_z !== exp_rsp.new_z ||
                    rsp.zero_norm !== exp_rsp.zero_norm)
                begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d zn=%0b",
                                 exp_rsp.new_w, exp_rsp.new_x, exp_rsp.new_y,
                                 exp_rsp.new_z, exp_rsp.zero_norm);
                        $display("          got      w=%0d x=%0d y=%0d z=%0d zn=%0b",
                                 rsp.new_w, rsp.new_x, rsp.new_y, rsp.new_z,
                                 rsp.zero_norm);
                    end
                end
            end
        end
    end

    // Present one request after a random gap and hold it until it is taken.
    task automatic send_request(qhi_pkg::req_t r, bit typed, qhi_pkg::rsp_t want);
        int gap;
        int prev;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        prev = accepted_cnt;
        start <= 1'b1;
        req <= r;
        dir_pending.typed <= typed;
        dir_pending.want <= want;
        do
            @(negedge clk);
        while (accepted_cnt == prev);
    endtask

    // Let the pipeline empty completely.
    task automatic drain_pipeline();
        start <= 1'b0;
        dir_pending.typed <= 1'b0;
        @(negedge clk);
        while (attitude_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY_CYCLES) @(negedge clk);
    endtask

    task automatic write_step(logic [qhi_pkg::STEP_BITS-1:0] h);
        cfg_we <= 1'b1;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        step_now = h;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_component(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 32768) - 16384);
            default: return 16'($urandom_range(0, 2048) - 1024);
        endcase
    endfunction

    function automatic qhi_pkg::req_t rand_request();
        qhi_pkg::req_t r;
        int   qm;
        int   rm;
        qm = $urandom_range(0, 2);
        rm = $urandom_range(0, 2);
        r.quat_w = rand_component(qm);
        r.quat_x = rand_component(qm);
        r.quat_y = rand_component(qm);
        r.quat_z = rand_component(qm);
        r.rate_x = rand_component(rm);
        r.rate_y = rand_component(rm);
        r.rate_z = rand_component(rm);
        if ($urandom_range(0, 40) == 0)
        begin
            r.quat_w = '0;
            r.quat_x = '0;
            r.quat_y = '0;
            r.quat_z = '0;
        end
        return r;
    endfunction

    function automatic row_t mk_row(int w, int x, int y, int z, int rx, int ry, int rz,
                                    bit typed, int ew, int ex, int ey, int ez, bit zn);
        row_t t;
        t.rq = '{16'(w), 16'(x), 16'(y), 16'(z), 16'(rx), 16'(ry), 16'(rz)};
        t.typed = typed;
        t.want = '{16'(ew), 16'(ex), 16'(ey), 16'(ez), zn};
        return t;
    endfunction

    initial
    begin
        logic [qhi_pkg::STEP_BITS-1:0] steps[6];
        row_t rw;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        dir_pending.typed = 1'b0;
        dir_pending.want = '0;
        accepted_cnt = 0;
        result_cnt = 0;
        zero_cnt = 0;
        mismatch_cnt = 0;
        step_now = qhi_pkg::STEP_RESET;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows at the reset step size.
        dir_rows.push_back(mk_row(0, 0, 0, 0, 100, -200, 300, 1, 0, 0, 0, 0, 1));
        dir_rows.push_back(mk_row(0, 0, 0, 0, -32768, 32767, 0, 1, 0, 0, 0, 0, 1));
        dir_rows.push_back(mk_row(16384, 0, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(-32768, 0, 0, 0, 0, 0, 0, 1, -16384, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(1, 0, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 0, -1, 0, 0, 0, 1, 0, 0, 0, -16384, 0));
        dir_rows.push_back(mk_row(0, 32767, 0, 0, 0, 0, 0, 1, 0, 16384, 0, 0, 0));
        dir_rows.push_back(mk_row(-32768, -32768, -32768, -32768, 0, 0, 0,
                                  1, -8192, -8192, -8192, -8192, 0));
        dir_rows.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                  0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(-32768, 32767, -32768, 32767, -32768, -32768, -32768,
                                  0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(16384, 0, 0, 0, 2048, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 16384, 0, 0, 0, 2048, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16384, 0, 0, 0, -2048, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(11585, 0, 0, 11585, 1000, -1000, 500, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(3, -4, 0, 0, -5, 7, 9, 0, 0, 0, 0, 0, 0));
        foreach (dir_rows[i])
        begin
            rw = dir_rows[i];
            send_request(rw.rq, rw.typed, rw.want);
        end
        drain_pipeline();

        // Random requests over several step sizes, extremes included.
        steps[0] = 16'd0;
        steps[1] = 16'hFFFF;
        steps[2] = 16'd66;
        steps[3] = 16'($urandom);
        steps[4] = 16'($urandom_range(1, 4000));
        steps[5] = 16'h8000;
        for (int p = 0; p < 6; p++)
        begin
            write_step(steps[p]);
            if (p == 1)
            begin
                // Saturating extremes with the largest step.
                rw = mk_row(32767, 0, 0, 0, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0);
                send_request(rw.rq, 1'b0, '0);
                rw = mk_row(-32768, 0, 0, 0, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0);
                send_request(rw.rq, 1'b0, '0);
            end
            for (int k = 0; k < 190; k++)
                send_request(rand_request(), 1'b0, '0);
            drain_pipeline();
        end

        $display("covered %0d requests, %0d results (%0d zero-norm), six step sizes",
                 accepted_cnt, result_cnt, zero_cnt);
        $display("mismatches: %0d", mismatch_cnt);
        if (mismatch_cnt == 0 && attitude_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/core/qhi_pkg.sv
rtl/core/qhi_isqrt.sv
rtl/core/qhi_div.sv
rtl/core/qhi_omega.sv
rtl/core/quaternion_heun_integrator_top.sv
tb/testbench.sv
